@@ rtl/assert_macros.svh @@
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every rising clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/mctt_pkg.sv @@
// types and command codes of the multi-channel task timer
package mctt_pkg;

	// command codes
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_CREATE  = 3'd1;
	localparam logic [2:0] CMD_ENABLE  = 3'd2;
	localparam logic [2:0] CMD_DISABLE = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;
	localparam logic [2:0] CMD_SETPER  = 3'd5;

	// command transfer payload
	typedef struct packed {
		logic [2:0]  command;
		logic [2:0]  task_index;
		logic [31:0] period_value;
		logic [31:0] delta_ticks;
		logic        start_enabled;
		logic        one_shot;
	} mctt_cmd_t;

	// response transfer payload
	typedef struct packed {
		logic [7:0] fired_mask;
		logic [2:0] new_index;
		logic       create_ok;
		logic [3:0] channels_used;
	} mctt_rsp_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_POST
	} mctt_state_t;

	// sequencer controls to the datapath
	typedef struct packed {
		logic cmd_ready;
		logic latch;
		logic tick_step;
		logic commit;
	} mctt_ctl_t;

endpackage

@@ rtl/mctt_tick_unit.sv @@
// shared saturating add and period compare for one channel
module mctt_tick_unit
	import mctt_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic [COUNT_WIDTH-1:0] elapsed,
	input  logic [31:0]            delta,
	input  logic [COUNT_WIDTH-1:0] period,
	output logic [COUNT_WIDTH-1:0] next_elapsed,
	output logic                   fire
);

	localparam int SW = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;

	logic [SW-1:0]          sum;
	logic [SW-1:0]          max_ext;
	logic [COUNT_WIDTH-1:0] sat;

	// add with saturation at the counter width
	always_comb begin
		max_ext = SW'({COUNT_WIDTH{1'b1}});
		sum     = SW'(elapsed) + SW'(delta);
		if (sum > max_ext) begin
			sat = {COUNT_WIDTH{1'b1}};
		end else begin
			sat = sum[COUNT_WIDTH-1:0];
		end
	end

	// fire when the count reaches the period
	assign fire         = (sat >= period);
	assign next_elapsed = fire ? '0 : sat;

endmodule

@@ rtl/mctt_seq.sv @@
// sequencer: command latch, channel sweep for ticks, response hand-off
module mctt_seq
	import mctt_pkg::*;
#(
	parameter int NUM_CHANNELS = 8,
	parameter int CH_W         = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  logic            is_tick,
	input  logic            out_free,
	output mctt_ctl_t       ctl,
	output logic [CH_W-1:0] ch
);

	mctt_state_t     state_q, state_d;
	logic [CH_W-1:0] ch_q, ch_d;

	// state and channel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d = state_q;
		ch_d    = ch_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl.latch = 1'b1;
					ch_d      = '0;
					state_d   = is_tick ? ST_TICK : ST_POST;
				end
			end
			ST_TICK: begin
				ctl.tick_step = 1'b1;
				if (ch_q == CH_W'(NUM_CHANNELS - 1)) begin
					state_d = ST_POST;
				end else begin
					ch_d = ch_q + 1'b1;
				end
			end
			ST_POST: begin
				if (out_free) begin
					ctl.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign ch = ch_q;

endmodule

@@ rtl/multi_channel_task_timer_top.sv @@
// top level of the multi-channel task timer
//
//   channel  | signals                      | payload
//   ---------+------------------------------+-----------
//   command  | cmd_valid / cmd_ready / cmd  | mctt_cmd_t
//   response | rsp_valid / rsp_ready / rsp  | mctt_rsp_t
//
// a tick sweeps the channels in ST_TICK, one channel per cycle through the
// shared saturating add and compare unit; every command then loads its
// response in ST_POST once the response register is free; ready
// returns the cycle after the load, so one command is in work at a time
// the response register holds a result until taken; a new command is
// accepted while it waits, and the next result waits for the register
// reset clears the enable flags, the channel count, the sequencer and rsp_valid
module multi_channel_task_timer_top
	import mctt_pkg::*;
#(
	parameter int NUM_CHANNELS = 8,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  mctt_cmd_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output mctt_rsp_t rsp
);

	localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int AW    = $clog2(NUM_CHANNELS + 1);
	localparam int CMP_W = (AW > 3) ? AW : 3;

	mctt_ctl_t              ctl;
	logic [CH_W-1:0]        ch;
	logic                   out_free;
	mctt_cmd_t              item_q;
	logic [7:0]             mask_q;
	logic [COUNT_WIDTH-1:0] period_q  [NUM_CHANNELS];
	logic [COUNT_WIDTH-1:0] elapsed_q [NUM_CHANNELS];
	logic                   oneshot_q [NUM_CHANNELS];
	logic                   enable_q  [NUM_CHANNELS];
	logic [AW-1:0]          alloc_q;
	logic                   rsp_valid_q;
	mctt_rsp_t              rsp_q;
	mctt_rsp_t              res;
	logic [COUNT_WIDTH-1:0] next_elapsed;
	logic                   fire;
	logic                   active;
	logic                   full;
	logic                   idx_hit;
	logic [CH_W-1:0]        idx;
	logic [CH_W-1:0]        new_ch;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign cmd_ready = ctl.cmd_ready;

	// sequencer
	mctt_seq #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.CH_W(CH_W)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.is_tick(cmd.command == CMD_TICK),
		.out_free(out_free),
		.ctl(ctl),
		.ch(ch)
	);

	// shared arithmetic unit, one channel per cycle
	mctt_tick_unit #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_tick (
		.elapsed(elapsed_q[ch]),
		.delta(item_q.delta_ticks),
		.period(period_q[ch]),
		.next_elapsed(next_elapsed),
		.fire(fire)
	);

	// decode of the latched command
	assign active  = enable_q[ch] && (AW'(ch) < alloc_q);
	assign full    = (alloc_q == AW'(NUM_CHANNELS));
	assign idx_hit = (CMP_W'(item_q.task_index) < CMP_W'(alloc_q));
	assign idx     = CH_W'(item_q.task_index);
	assign new_ch  = CH_W'(alloc_q);

	// command latch and fired mask
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			item_q <= cmd;
			mask_q <= '0;
		end else if (ctl.tick_step && active && fire && (32'(ch) < 32'd8)) begin
			mask_q[3'(ch)] <= 1'b1;
		end
	end

	// period, count and one-shot tables
	always_ff @(posedge clk) begin
		if (ctl.tick_step && active) begin
			elapsed_q[ch] <= next_elapsed;
		end
		if (ctl.commit) begin
			case (item_q.command)
				CMD_CREATE: begin
					if (!full) begin
						period_q[new_ch]  <= COUNT_WIDTH'(item_q.period_value);
						elapsed_q[new_ch] <= '0;
						oneshot_q[new_ch] <= item_q.one_shot;
					end
				end
				CMD_CLEAR: begin
					if (idx_hit) begin
						elapsed_q[idx] <= '0;
					end
				end
				CMD_SETPER: begin
					if (idx_hit) begin
						period_q[idx] <= COUNT_WIDTH'(item_q.period_value);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// enable flags and channel count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				enable_q[i] <= 1'b0;
			end
		end else begin
			if (ctl.tick_step && active && fire && oneshot_q[ch]) begin
				enable_q[ch] <= 1'b0;
			end
			if (ctl.commit) begin
				case (item_q.command)
					CMD_CREATE: begin
						if (!full) begin
							enable_q[new_ch] <= item_q.start_enabled;
							alloc_q          <= alloc_q + 1'b1;
						end
					end
					CMD_ENABLE: begin
						if (idx_hit) begin
							enable_q[idx] <= 1'b1;
						end
					end
					CMD_DISABLE: begin
						if (idx_hit) begin
							enable_q[idx] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// response fields
	always_comb begin
		res               = '0;
		res.channels_used = 4'(alloc_q);
		case (item_q.command)
			CMD_TICK: begin
				res.fired_mask = mask_q;
			end
			CMD_CREATE: begin
				if (!full) begin
					res.new_index     = 3'(alloc_q);
					res.create_ok     = 1'b1;
					res.channels_used = 4'(AW'(alloc_q + 1'b1));
				end
			end
			default: begin
			end
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/mctt_checker.sv @@
// port checker for the multi-channel task timer, with its bind
`include "assert_macros.svh"

module mctt_checker
	import mctt_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_ready,
	input mctt_cmd_t cmd,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input mctt_rsp_t rsp
);

	// a stalled response holds
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// one command in work at a time
	`ASSERT_NEXT(a_busy_after_xfer, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready)

	// a failed or absent create reports index zero
	`ASSERT_HOLDS(a_no_index, clk, arst_n, !rsp_valid || rsp.create_ok || rsp.new_index == 3'd0)

	// a good create reports no firing and counts the new channel
	`ASSERT_HOLDS(a_create_count, clk, arst_n, !rsp_valid || !rsp.create_ok || (rsp.fired_mask == 8'd0 && rsp.channels_used[2:0] == 3'(rsp.new_index + 3'd1)))

endmodule

bind multi_channel_task_timer_top mctt_checker u_mctt_checker (.*);

@@ dv/multi_channel_task_timer_top_tb.sv @@
// self-checking testbench for the multi-channel task timer top level
module multi_channel_task_timer_top_tb;
	import mctt_pkg::*;

	localparam int NUM_CH = 8;
	localparam int RANDOM_ITEMS = 1050;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_OFF_START = 300;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES = 24;
	localparam int MAX_PRINTED = 50;

	// codes outside the defined command set
	localparam logic [2:0] CMD_RSVD_A = 3'd6;
	localparam logic [2:0] CMD_RSVD_B = 3'd7;

	// timer table predictor and queue of expected responses
	class timer_model;
		logic [31:0] period_tab[NUM_CH];
		logic [31:0] elapsed_tab[NUM_CH];
		bit enabled[NUM_CH];
		bit oneshot[NUM_CH];
		int used_count;
		int errors;
		mctt_rsp_t expected_rsp[$];

		function new();
			used_count = 0;
			errors = 0;
			for (int i = 0; i < NUM_CH; i++) begin
				period_tab[i] = '0;
				elapsed_tab[i] = '0;
				enabled[i] = 1'b0;
				oneshot[i] = 1'b0;
			end
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		// apply one accepted command and queue its response
		function void note_command(input mctt_cmd_t c);
			mctt_rsp_t r;
			logic [32:0] sum;
			logic [31:0] e;
			int i;
			r = '0;
			case (c.command)
				CMD_TICK: begin
					for (i = 0; i < used_count; i++) begin
						if (enabled[i]) begin
							sum = {1'b0, elapsed_tab[i]} + {1'b0, c.delta_ticks};
							e = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
							if (e >= period_tab[i]) begin
								e = '0;
								if (oneshot[i])
									enabled[i] = 1'b0;
								r.fired_mask[i] = 1'b1;
							end
							elapsed_tab[i] = e;
						end
					end
				end
				CMD_CREATE: begin
					if (used_count < NUM_CH) begin
						period_tab[used_count] = c.period_value;
						elapsed_tab[used_count] = '0;
						enabled[used_count] = c.start_enabled;
						oneshot[used_count] = c.one_shot;
						r.new_index = used_count[2:0];
						r.create_ok = 1'b1;
						used_count++;
					end
				end
				CMD_ENABLE, CMD_DISABLE, CMD_CLEAR, CMD_SETPER: begin
					// commands naming an unallocated channel are dropped
					if (int'(c.task_index) < used_count) begin
						case (c.command)
							CMD_ENABLE:  enabled[c.task_index] = 1'b1;
							CMD_DISABLE: enabled[c.task_index] = 1'b0;
							CMD_CLEAR:   elapsed_tab[c.task_index] = '0;
							default:     period_tab[c.task_index] = c.period_value;
						endcase
					end
				end
				default: begin
				end
			endcase
			r.channels_used = used_count[3:0];
			expected_rsp.push_back(r);
		endfunction

		// compare a response transfer with the oldest expectation
		task check_response(input mctt_rsp_t got);
			mctt_rsp_t exp_rsp;
			if (expected_rsp.size() == 0) begin
				report("response with no command outstanding");
			end else begin
				exp_rsp = expected_rsp.pop_front();
				if (got.fired_mask !== exp_rsp.fired_mask)
					report($sformatf("fired_mask got %h exp %h",
						got.fired_mask, exp_rsp.fired_mask));
				if (got.new_index !== exp_rsp.new_index)
					report($sformatf("new_index got %0d exp %0d",
						got.new_index, exp_rsp.new_index));
				if (got.create_ok !== exp_rsp.create_ok)
					report($sformatf("create_ok got %b exp %b",
						got.create_ok, exp_rsp.create_ok));
				if (got.channels_used !== exp_rsp.channels_used)
					report($sformatf("channels_used got %0d exp %0d",
						got.channels_used, exp_rsp.channels_used));
			end
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	mctt_cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	mctt_rsp_t rsp;

	timer_model model;
	mctt_cmd_t stim[$];
	int sent_count = 0;
	int cycle_count = 0;
	logic hold_off = 1'b0;
	int recv_mode = 0;
	int recv_left = 0;

	multi_channel_task_timer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic mctt_cmd_t mk(input logic [2:0] op, input logic [2:0] idx,
		input logic [31:0] per, input logic [31:0] dt, input logic en, input logic os);
		mctt_cmd_t c;
		c.command = op;
		c.task_index = idx;
		c.period_value = per;
		c.delta_ticks = dt;
		c.start_enabled = en;
		c.one_shot = os;
		return c;
	endfunction

	// random command, weighted toward ticks and channel edits
	function automatic mctt_cmd_t random_command();
		mctt_cmd_t c;
		int r;
		r = $urandom_range(0, 99);
		if (r < 38)
			c.command = CMD_TICK;
		else if (r < 50)
			c.command = CMD_ENABLE;
		else if (r < 60)
			c.command = CMD_DISABLE;
		else if (r < 68)
			c.command = CMD_CLEAR;
		else if (r < 84)
			c.command = CMD_SETPER;
		else if (r < 94)
			c.command = CMD_CREATE;
		else
			c.command = ($urandom_range(0, 1) != 0) ? CMD_RSVD_A : CMD_RSVD_B;
		c.task_index = 3'($urandom_range(0, NUM_CH - 1));
		r = $urandom_range(0, 99);
		if (r < 70)
			c.period_value = 32'($urandom_range(0, 40));
		else if (r < 85)
			c.period_value = 32'($urandom_range(0, 400));
		else if (r < 95)
			c.period_value = $urandom();
		else
			c.period_value = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
		r = $urandom_range(0, 99);
		if (r < 75)
			c.delta_ticks = 32'($urandom_range(0, 12));
		else if (r < 90)
			c.delta_ticks = 32'($urandom_range(0, 100));
		else if (r < 97)
			c.delta_ticks = $urandom();
		else
			c.delta_ticks = 32'hFFFF_FFFF;
		c.start_enabled = 1'($urandom_range(0, 1));
		c.one_shot = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// one command transfer
	task automatic send_command(input mctt_cmd_t c);
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		model.note_command(c);
		sent_count++;
	endtask

	// response side: checks each response taken; stall pattern that changes mode now and then
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			model.check_response(rsp);
		if (recv_left == 0) begin
			recv_mode = $urandom_range(0, 3);
			recv_left = $urandom_range(20, 150);
		end else begin
			recv_left--;
		end
		if (hold_off)
			rsp_ready <= 1'b0;
		else begin
			case (recv_mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= ($urandom_range(0, 1) != 0);
				2: rsp_ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// long response hold-off while commands keep coming
	initial begin
		wait (sent_count >= HOLD_OFF_START);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// main sequence
	initial begin
		int idx;
		int burst;
		int gap;
		model = new();

		// directed: unallocated channels, reserved codes, zero and full periods,
		// saturation, one-shot self disable and a create on a full table
		stim.push_back(mk(CMD_ENABLE,  3'd0, 32'd0, 32'd0, 1'b0, 1'b0));
		stim.push_back(mk(CMD_SETPER,  3'd7, 32'd5, 32'd0, 1'b1, 1'b1));
		stim.push_back(mk(CMD_CLEAR,   3'd3, 32'd0, 32'd9, 1'b0, 1'b1));
		stim.push_back(mk(CMD_DISABLE, 3'd0, 32'd0, 32'd0, 1'b1, 1'b0));
		stim.push_back(mk(CMD_TICK,    3'd0, 32'd0, 32'd5, 1'b0, 1'b0));
		stim.push_back(mk(CMD_RSVD_A,  3'd2, $urandom(), $urandom(), 1'b1, 1'b1));
		stim.push_back(mk(CMD_RSVD_B,  3'd5, $urandom(), $urandom(), 1'b1, 1'b0));
		stim.push_back(mk(CMD_CREATE,  3'd0, 32'd0, 32'd0, 1'b1, 1'b0));
		stim.push_back(mk(CMD_CREATE,  3'd7, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1));
		stim.push_back(mk(CMD_CREATE,  3'd0, 32'd3, 32'd0, 1'b0, 1'b1));
		stim.push_back(mk(CMD_ENABLE,  3'd5, 32'd0, 32'd0, 1'b0, 1'b0));
		stim.push_back(mk(CMD_TICK,    3'd0, 32'd0, 32'd0, 1'b0, 1'b0));
		stim.push_back(mk(CMD_TICK,    3'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0));
		stim.push_back(mk(CMD_ENABLE,  3'd2, 32'd0, 32'd0, 1'b0, 1'b0));
		stim.push_back(mk(CMD_TICK,    3'd0, 32'd0, 32'd1, 1'b0, 1'b0));
		stim.push_back(mk(CMD_TICK,    3'd0, 32'd0, 32'd2, 1'b0, 1'b0));
		stim.push_back(mk(CMD_CREATE,  3'd0, 32'd10, 32'd0, 1'b1, 1'b0));
		stim.push_back(mk(CMD_CREATE,  3'd0, 32'd1, 32'd0, 1'b1, 1'b1));
		stim.push_back(mk(CMD_CREATE,  3'd0, 32'd7, 32'd0, 1'b0, 1'b0));
		stim.push_back(mk(CMD_CREATE,  3'd0, 32'd2, 32'd0, 1'b1, 1'b0));
		stim.push_back(mk(CMD_CREATE,  3'd0, 32'd4, 32'd0, 1'b1, 1'b1));
		stim.push_back(mk(CMD_CREATE,  3'd0, 32'd9, 32'd0, 1'b1, 1'b1));
		stim.push_back(mk(CMD_SETPER,  3'd3, 32'd1, 32'd0, 1'b0, 1'b0));
		stim.push_back(mk(CMD_DISABLE, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0));
		stim.push_back(mk(CMD_TICK,    3'd0, 32'd0, 32'd6, 1'b0, 1'b0));
		stim.push_back(mk(CMD_ENABLE,  3'd1, 32'd0, 32'd0, 1'b0, 1'b0));
		for (idx = 0; idx < RANDOM_ITEMS; idx++)
			stim.push_back(random_command());

		// reset
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bursts of transfers with random gaps between them
		idx = 0;
		while (idx < stim.size()) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && idx < stim.size(); k++) begin
				send_command(stim[idx]);
				idx++;
			end
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		cmd_valid <= 1'b0;

		// drain
		while (model.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (model.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mctt_pkg.sv
rtl/mctt_tick_unit.sv
rtl/mctt_seq.sv
rtl/multi_channel_task_timer_top.sv
rtl/mctt_checker.sv
dv/multi_channel_task_timer_top_tb.sv
